>>> src/trdt_pkg.sv
`default_nettype none
package trdt_pkg;

  // request and result kinds
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_FAR_DEPTH = 2'd0;
  localparam logic [1:0] CFG_CLIP_EN   = 2'd1;

  localparam logic [23:0] GREY = 24'h3C3C3C;

  // datapath widths: wide numerator / quotient, divisor, edge value
  localparam int MW = 56;
  localparam int TW = 36;
  localparam int EW = 36;

  // setup multiply steps
  localparam logic [4:0] MS_D_P    = 5'd0;
  localparam logic [4:0] MS_D_N    = 5'd1;
  localparam logic [4:0] MS_EAB_P  = 5'd2;
  localparam logic [4:0] MS_EAB_N  = 5'd3;
  localparam logic [4:0] MS_EBC_P  = 5'd4;
  localparam logic [4:0] MS_EBC_N  = 5'd5;
  localparam logic [4:0] MS_ECA_P  = 5'd6;
  localparam logic [4:0] MS_ECA_N  = 5'd7;
  localparam logic [4:0] MS_NX_A   = 5'd8;
  localparam logic [4:0] MS_NX_B   = 5'd9;
  localparam logic [4:0] MS_NX_C   = 5'd10;
  localparam logic [4:0] MS_NY_A   = 5'd11;
  localparam logic [4:0] MS_NY_B   = 5'd12;
  localparam logic [4:0] MS_NY_C   = 5'd13;
  localparam logic [4:0] MS_N0_A   = 5'd14;
  localparam logic [4:0] MS_N0_B   = 5'd15;
  localparam logic [4:0] MS_N0_C   = 5'd16;
  localparam logic [4:0] MS_LAST   = MS_N0_C;

  // division selects
  localparam logic [1:0] DIV_ORIGIN = 2'd0;
  localparam logic [1:0] DIV_XSTEP  = 2'd1;
  localparam logic [1:0] DIV_YSTEP  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] bx;
    logic signed [15:0] by_coord;
    logic signed [15:0] bz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [23:0]        tri_color;
    logic [11:0]        pixel_index;
  } req_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [23:0]        pixel_color;
    logic signed [15:0] pixel_depth;
    logic [12:0]        pixels_written;
  } res_t;

  typedef struct packed {
    logic       latch;
    logic       mul_en;
    logic [4:0] mul_step;
    logic       walk_init;
    logic       walk_en;
    logic       div_start;
    logic [1:0] div_sel;
    logic       sweep_en;
    logic       read_issue;
    logic       result_load;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic div_done;
    logic walk_last;
    logic sweep_last;
  } sts_t;

  typedef struct packed {
    logic signed [MW-1:0] q;
    logic [TW-1:0]        r;
  } qr_t;

endpackage
`default_nettype wire

>>> src/trdt_ram.sv
`default_nettype none
module trdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/trdt_div.sv
`default_nettype none
module trdt_div
  import trdt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [MW-1:0] num,
  input  wire logic [TW-1:0]        den,
  output logic                      done,
  output logic signed [MW-1:0]      quo,
  output logic [TW-1:0]             rem
);

  logic                     run;
  logic [$clog2(MW)-1:0]    cnt;
  logic [MW-1:0]            mag;
  logic [MW-1:0]            qacc;
  logic [TW-1:0]            racc;
  logic                     neg;
  logic [TW:0]              trial;
  logic                     fits;

  // restoring step, one quotient bit per cycle
  assign trial = {racc, mag[MW-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(MW))'(MW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[MW-1];
      mag  <= num[MW-1] ? MW'(-num) : MW'(num);
      racc <= '0;
      qacc <= '0;
    end else if (run) begin
      racc <= fits ? TW'(trial - {1'b0, den}) : TW'(trial);
      qacc <= {qacc[MW-2:0], fits};
      mag  <= {mag[MW-2:0], 1'b0};
    end
  end

  // floor semantics for a negative numerator
  always_comb begin
    if (neg && racc != '0) begin
      quo = $signed(~qacc);
      rem = den - racc;
    end else if (neg) begin
      quo = $signed(-qacc);
      rem = racc;
    end else begin
      quo = $signed(qacc);
      rem = racc;
    end
  end

endmodule
`default_nettype wire

>>> src/trdt_ctrl.sv
`default_nettype none
module trdt_ctrl
  import trdt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] req_type,
  input  wire sts_t       sts,
  output logic            busy,
  output cmd_t            cmd
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CLEAR    = 4'd2;
  localparam logic [3:0] S_SETUP    = 4'd3;
  localparam logic [3:0] S_CHECK    = 4'd4;
  localparam logic [3:0] S_DIV_GO   = 4'd5;
  localparam logic [3:0] S_DIV_WAIT = 4'd6;
  localparam logic [3:0] S_WALK     = 4'd7;
  localparam logic [3:0] S_DRAIN    = 4'd8;
  localparam logic [3:0] S_READ     = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state, state_next;
  logic [4:0] step, step_next;
  logic [1:0] sel, sel_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      step  <= '0;
      sel   <= DIV_ORIGIN;
    end else begin
      state <= state_next;
      step  <= step_next;
      sel   <= sel_next;
    end
  end

  // sequencing of clear, draw and read
  always_comb begin
    cmd          = '0;
    cmd.mul_step = step;
    cmd.div_sel  = sel;
    state_next   = state;
    step_next    = step;
    sel_next     = sel;
    unique case (state)
      S_INIT: begin
        cmd.sweep_en = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (req_type)
            REQ_CLEAR: state_next = S_CLEAR;
            REQ_DRAW: begin
              state_next = S_SETUP;
              step_next  = MS_D_P;
            end
            REQ_READ:  state_next = S_READ;
            REQ_NONE:  state_next = S_IDLE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sweep_en = 1'b1;
        if (sts.sweep_last) state_next = S_DONE;
      end
      S_SETUP: begin
        cmd.mul_en = 1'b1;
        step_next  = step + 1'b1;
        if (step == MS_LAST) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.reject) begin
          state_next = S_DONE;
        end else begin
          cmd.walk_init = 1'b1;
          sel_next      = DIV_ORIGIN;
          state_next    = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          if (sel == DIV_YSTEP) begin
            state_next = S_WALK;
          end else begin
            sel_next   = sel + 1'b1;
            state_next = S_DIV_GO;
          end
        end
      end
      S_WALK: begin
        cmd.walk_en = 1'b1;
        if (sts.walk_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_DONE;
      S_READ: begin
        cmd.read_issue = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        cmd.result_load = 1'b1;
        state_next      = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> src/trdt_dp.sv
`default_nettype none
module trdt_dp
  import trdt_pkg::*;
#(
  parameter int FB_WIDTH  = 64,
  parameter int FB_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire req_t        req,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             result_valid,
  output res_t             result
);

  localparam int NPIX = FB_WIDTH * FB_HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam int XW   = $clog2(FB_WIDTH);
  localparam int YW   = $clog2(FB_HEIGHT);

  // configuration registers
  logic signed [15:0] far_depth;
  logic               clip_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      far_depth <= 16'sd32767;
      clip_en   <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FAR_DEPTH) far_depth <= $signed(cfg_data);
      if (cfg_index == CFG_CLIP_EN)   clip_en   <= cfg_data[0];
    end
  end

  // bounding box of the incoming triangle
  logic signed [15:0] mnx, mny, mxx, mxy;
  logic signed [12:0] fx, fy, kx, ky, x0c, y0c, x1c, y1c;
  logic signed [16:0] kx_s, ky_s;

  always_comb begin
    mnx = req.ax < req.bx ? req.ax : req.bx;
    mnx = mnx < req.cx ? mnx : req.cx;
    mny = req.ay < req.by_coord ? req.ay : req.by_coord;
    mny = mny < req.cy ? mny : req.cy;
    mxx = req.ax > req.bx ? req.ax : req.bx;
    mxx = mxx > req.cx ? mxx : req.cx;
    mxy = req.ay > req.by_coord ? req.ay : req.by_coord;
    mxy = mxy > req.cy ? mxy : req.cy;
    fx  = 13'(mnx >>> 4);
    fy  = 13'(mny >>> 4);
    kx_s = 17'(mxx) + 17'sd15;
    ky_s = 17'(mxy) + 17'sd15;
    kx  = 13'(kx_s >>> 4);
    ky  = 13'(ky_s >>> 4);
    x0c = fx < 13'sd0 ? 13'sd0 : fx;
    y0c = fy < 13'sd0 ? 13'sd0 : fy;
    x1c = kx > $signed(13'(FB_WIDTH - 1)) ? $signed(13'(FB_WIDTH - 1)) : kx;
    y1c = ky > $signed(13'(FB_HEIGHT - 1)) ? $signed(13'(FB_HEIGHT - 1)) : ky;
  end

  // latched request
  req_t               rq;
  logic signed [12:0] x0s, y0s;
  logic [XW-1:0]      x0, x1;
  logic [YW-1:0]      y1;
  logic               empty;
  logic signed [16:0] dxab, dyab, dxbc, dybc, dxca, dyca;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rq    <= req;
      x0s   <= x0c;
      y0s   <= y0c;
      x0    <= XW'(x0c);
      x1    <= XW'(x1c);
      y1    <= YW'(y1c);
      empty <= (x1c <= x0c) || (y1c <= y0c);
      dxab  <= 17'(req.bx) - 17'(req.ax);
      dyab  <= 17'(req.by_coord) - 17'(req.ay);
      dxbc  <= 17'(req.cx) - 17'(req.bx);
      dybc  <= 17'(req.cy) - 17'(req.by_coord);
      dxca  <= 17'(req.ax) - 17'(req.cx);
      dyca  <= 17'(req.ay) - 17'(req.cy);
    end
  end

  // origin pixel centre
  logic signed [16:0] px0, py0;
  assign px0 = $signed({x0s, 4'b1000});
  assign py0 = $signed({y0s, 4'b1000});

  // shared setup multiplier
  logic signed [MW-1:0] acc_d, acc_eab, acc_ebc, acc_eca, acc_nx, acc_ny, acc_n0;
  logic signed [EW-1:0] mul_a;
  logic signed [17:0]   mul_b;
  logic signed [53:0]   prod;
  logic                 p_vld;
  logic [4:0]           p_step;

  always_comb begin
    unique case (cmd.mul_step)
      MS_D_P:   begin mul_a = EW'(dyab); mul_b = 18'(dxca); end
      MS_D_N:   begin mul_a = EW'(dxab); mul_b = 18'(dyca); end
      MS_EAB_P: begin mul_a = EW'(dxab); mul_b = 18'(py0) - 18'(rq.ay); end
      MS_EAB_N: begin mul_a = EW'(dyab); mul_b = 18'(px0) - 18'(rq.ax); end
      MS_EBC_P: begin mul_a = EW'(dxbc); mul_b = 18'(py0) - 18'(rq.by_coord); end
      MS_EBC_N: begin mul_a = EW'(dybc); mul_b = 18'(px0) - 18'(rq.bx); end
      MS_ECA_P: begin mul_a = EW'(dxca); mul_b = 18'(py0) - 18'(rq.cy); end
      MS_ECA_N: begin mul_a = EW'(dyca); mul_b = 18'(px0) - 18'(rq.cx); end
      MS_NX_A:  begin mul_a = EW'(dybc); mul_b = 18'(rq.az); end
      MS_NX_B:  begin mul_a = EW'(dyca); mul_b = 18'(rq.bz); end
      MS_NX_C:  begin mul_a = EW'(dyab); mul_b = 18'(rq.cz); end
      MS_NY_A:  begin mul_a = EW'(dxbc); mul_b = 18'(rq.az); end
      MS_NY_B:  begin mul_a = EW'(dxca); mul_b = 18'(rq.bz); end
      MS_NY_C:  begin mul_a = EW'(dxab); mul_b = 18'(rq.cz); end
      MS_N0_A:  begin mul_a = EW'(acc_ebc); mul_b = 18'(rq.az); end
      MS_N0_B:  begin mul_a = EW'(acc_eca); mul_b = 18'(rq.bz); end
      MS_N0_C:  begin mul_a = EW'(acc_eab); mul_b = 18'(rq.cz); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= mul_a * mul_b;
    p_step <= cmd.mul_step;
  end

  // accumulate each product into its sum
  logic signed [MW-1:0] pw;
  assign pw = MW'(prod);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      acc_d   <= '0;
      acc_eab <= '0;
      acc_ebc <= '0;
      acc_eca <= '0;
      acc_nx  <= '0;
      acc_ny  <= '0;
      acc_n0  <= '0;
    end else if (p_vld) begin
      unique case (p_step)
        MS_D_P:   acc_d   <= acc_d + pw;
        MS_D_N:   acc_d   <= acc_d - pw;
        MS_EAB_P: acc_eab <= acc_eab + pw;
        MS_EAB_N: acc_eab <= acc_eab - pw;
        MS_EBC_P: acc_ebc <= acc_ebc + pw;
        MS_EBC_N: acc_ebc <= acc_ebc - pw;
        MS_ECA_P: acc_eca <= acc_eca + pw;
        MS_ECA_N: acc_eca <= acc_eca - pw;
        MS_NX_A, MS_NX_B, MS_NX_C: acc_nx <= acc_nx + pw;
        MS_NY_A, MS_NY_B, MS_NY_C: acc_ny <= acc_ny + pw;
        MS_N0_A, MS_N0_B, MS_N0_C: acc_n0 <= acc_n0 + pw;
        default: acc_d <= acc_d;
      endcase
    end
  end

  // draw rejection: clipped depth, no area or empty box
  assign sts.reject = (clip_en && (rq.az < 0 || rq.bz < 0 || rq.cz < 0))
                      || (acc_d <= 0) || empty;

  // divisions by twice the cross product, that is four times the area
  logic [TW-1:0]        tden;
  logic signed [MW-1:0] div_num;
  logic signed [MW-1:0] div_q;
  logic [TW-1:0]        div_r;
  logic                 div_done;

  assign tden = {acc_d[TW-2:0], 1'b0};

  always_comb begin
    unique case (cmd.div_sel)
      DIV_ORIGIN: div_num = (acc_n0 <<< 1) + acc_d;
      DIV_XSTEP:  div_num = -(acc_nx <<< 5);
      DIV_YSTEP:  div_num = acc_ny <<< 5;
      default:    div_num = '0;
    endcase
  end

  trdt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (tden),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  assign sts.div_done = div_done;

  // quotient/remainder step with carry of the remainder
  function automatic qr_t qr_add(qr_t a, qr_t b, logic [TW-1:0] t);
    logic [TW:0] s;
    qr_t         o;
    s = {1'b0, a.r} + {1'b0, b.r};
    if (s >= {1'b0, t}) begin
      o.r = TW'(s - {1'b0, t});
      o.q = a.q + b.q + MW'(1);
    end else begin
      o.r = TW'(s);
      o.q = a.q + b.q;
    end
    return o;
  endfunction

  qr_t qx, qy, qrow, qcur, qrow_next, qcur_next;

  // pixel walk over the box, edges stepped per pixel
  logic [XW-1:0]        x;
  logic [YW-1:0]        y;
  logic signed [EW-1:0] rab, rbc, rca, eab, ebc, eca;
  logic signed [EW-1:0] xab, xbc, xca, yab, ybc, yca;
  logic                 last_col;

  assign xab = -(EW'(dyab) <<< 4);
  assign xbc = -(EW'(dybc) <<< 4);
  assign xca = -(EW'(dyca) <<< 4);
  assign yab = EW'(dxab) <<< 4;
  assign ybc = EW'(dxbc) <<< 4;
  assign yca = EW'(dxca) <<< 4;

  assign last_col      = x == x1 - 1'b1;
  assign sts.walk_last = last_col && (y == y1 - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      x   <= x0;
      y   <= YW'(y0s);
      rab <= EW'(acc_eab);
      rbc <= EW'(acc_ebc);
      rca <= EW'(acc_eca);
      eab <= EW'(acc_eab);
      ebc <= EW'(acc_ebc);
      eca <= EW'(acc_eca);
    end else if (cmd.walk_en) begin
      if (last_col) begin
        x   <= x0;
        y   <= y + 1'b1;
        rab <= rab + yab;
        rbc <= rbc + ybc;
        rca <= rca + yca;
        eab <= rab + yab;
        ebc <= rbc + ybc;
        eca <= rca + yca;
      end else begin
        x   <= x + 1'b1;
        eab <= eab + xab;
        ebc <= ebc + xbc;
        eca <= eca + xca;
      end
    end
  end

  // depth stepped along the walk as quotient and remainder
  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd.div_sel)
        DIV_ORIGIN: begin
          qrow <= '{q: div_q, r: div_r};
          qcur <= '{q: div_q, r: div_r};
        end
        DIV_XSTEP: qx <= '{q: div_q, r: div_r};
        DIV_YSTEP: qy <= '{q: div_q, r: div_r};
        default:   qx <= qx;
      endcase
    end else if (cmd.walk_en) begin
      if (last_col) begin
        qrow <= qrow_next;
        qcur <= qrow_next;
      end else begin
        qcur <= qcur_next;
      end
    end
  end

  assign qrow_next = qr_add(qrow, qy, tden);
  assign qcur_next = qr_add(qcur, qx, tden);

  // pixel address at the flipped row, and saturated depth
  logic [YW-1:0]      rowflip;
  logic [AW-1:0]      walk_addr;
  logic signed [15:0] zsat;
  logic               covered;

  assign rowflip   = YW'(FB_HEIGHT - 1) - y;
  assign walk_addr = AW'(32'(rowflip) * FB_WIDTH + 32'(x));
  assign covered   = !eab[EW-1] && !ebc[EW-1] && !eca[EW-1];

  always_comb begin
    if (qcur.q > MW'(32767)) begin
      zsat = 16'sd32767;
    end else if (qcur.q < -MW'(32768)) begin
      zsat = -16'sd32768;
    end else begin
      zsat = 16'(qcur.q);
    end
  end

  // depth test stage, one pixel behind the walk
  logic               s1_vld;
  logic [AW-1:0]      s1_addr;
  logic signed [15:0] s1_z;
  logic signed [15:0] rd_depth;
  logic [23:0]        rd_color;
  logic               hit;
  logic [12:0]        count;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= cmd.walk_en && covered;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= walk_addr;
    s1_z    <= zsat;
  end

  assign hit = s1_vld && (s1_z < rd_depth);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      count <= '0;
    end else if (hit) begin
      count <= count + 1'b1;
    end
  end

  // clearing sweep
  logic [AW-1:0] sweep_addr;

  assign sts.sweep_last = sweep_addr == AW'(NPIX - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_en) begin
      sweep_addr <= sts.sweep_last ? '0 : sweep_addr + 1'b1;
    end
  end

  // store ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   wcolor;
  logic [15:0]   wdepth;
  logic [15:0]   rdepth_raw;
  logic          in_frame;

  assign in_frame = {1'b0, rq.pixel_index} < 13'(NPIX);

  always_comb begin
    if (cmd.sweep_en) begin
      we     = 1'b1;
      waddr  = sweep_addr;
      wcolor = GREY;
      wdepth = far_depth;
    end else begin
      we     = hit;
      waddr  = s1_addr;
      wcolor = rq.tri_color;
      wdepth = s1_z;
    end
    raddr = cmd.walk_en ? walk_addr : AW'(rq.pixel_index);
  end

  assign rd_depth = $signed(rdepth_raw);

  trdt_ram #(.WIDTH(24), .DEPTH(NPIX)) u_color (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wcolor),
    .raddr (raddr),
    .rdata (rd_color)
  );

  trdt_ram #(.WIDTH(16), .DEPTH(NPIX)) u_depth (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdepth),
    .raddr (raddr),
    .rdata (rdepth_raw)
  );

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.result_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      result.result_kind    <= rq.req_type;
      result.pixel_color    <= (rq.req_type == REQ_READ && in_frame) ? rd_color : '0;
      result.pixel_depth    <= (rq.req_type == REQ_READ && in_frame) ? rd_depth : '0;
      result.pixels_written <= (rq.req_type == REQ_DRAW) ? count : '0;
    end
  end

endmodule
`default_nettype wire

>>> src/triangle_rasterizer_depth_test.sv
// Triangle rasterizer with a depth store over an FB_WIDTH x FB_HEIGHT frame.
// Requests: raise start with req for one cycle while busy is low; the request
// is taken at that edge. Kinds are clear, draw and read; kind 3 is dropped.
// Each taken request (but kind 3) gives one result: result_valid is high for
// exactly one cycle with result, and the receiver must take it then.
// Configuration: cfg_valid/cfg_ready (ready always high) with cfg_index and
// cfg_data; write only while busy is low and no result is pending.
// Work from the taking edge to the result:
//   read  - the store read, then the result
//   clear - a sweep over every store entry (one store entry written per cycle)
//   draw  - 17 setup steps on one shared multiplier and a check state, then
//           three runs of the serial divider (start depth and its x and y
//           steps), then the walk over the clipped bounding box;
//           a rejected or empty draw ends after the check
// The box walk bounds a draw: at most (FB_WIDTH-1) x (FB_HEIGHT-1) pixels.
// One request at a time: busy drops with the result.
// Reset: synchronous, active high. After reset the block sweeps both stores
// to grey and the far depth with busy high.
`default_nettype none
module triangle_rasterizer_depth_test
  import trdt_pkg::*;
#(
  parameter int FB_WIDTH  = 64,
  parameter int FB_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req,
  output logic             result_valid,
  output res_t             result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  trdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  trdt_dp #(.FB_WIDTH(FB_WIDTH), .FB_HEIGHT(FB_HEIGHT)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire

>>> verif/tb_triangle_rasterizer_depth_test.sv
`default_nettype none
module tb_triangle_rasterizer_depth_test;
  import trdt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 64;
  localparam int H = 64;
  localparam int NPIX = W * H;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        result_valid;
  res_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  triangle_rasterizer_depth_test #(.FB_WIDTH(W), .FB_HEIGHT(H)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predicted frame contents and register copies
  logic [23:0]        shadow_color [NPIX];
  logic signed [15:0] shadow_depth [NPIX];
  logic signed [15:0] far_z = 16'sd32767;
  logic               clip_on = 1'b1;

  req_t pending_reqs[$];
  res_t results_due[$];
  int   idle_pct = 0;
  int   errors = 0;
  int   cycles = 0;

  initial begin
    for (int i = 0; i < NPIX; i++) begin
      shadow_color[i] = GREY;
      shadow_depth[i] = 16'sd32767;
    end
  end

  function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  // rasterize one triangle into the shadow frame, return pixels written
  function automatic int rasterize_draw(req_t r);
    longint ax, ay, az, bx, by, bz, cx, cy, cz, d, px, py, eab, ebc, eca, num, z, q;
    longint x0, y0, x1, y1;
    int idx;
    int count;
    ax = r.ax; ay = r.ay; az = r.az;
    bx = r.bx; by = r.by_coord; bz = r.bz;
    cx = r.cx; cy = r.cy; cz = r.cz;
    count = 0;
    if (clip_on && (az < 0 || bz < 0 || cz < 0)) return 0;
    d = cross2(bx - ax, by - ay, cx - ax, cy - ay);
    if (d <= 0) return 0;
    // pixel bounding box, floor of min and ceil of max, clipped
    x0 = (ax < bx ? ax : bx); x0 = (x0 < cx ? x0 : cx); x0 = x0 >>> 4;
    y0 = (ay < by ? ay : by); y0 = (y0 < cy ? y0 : cy); y0 = y0 >>> 4;
    x1 = (ax > bx ? ax : bx); x1 = (x1 > cx ? x1 : cx); x1 = (x1 + 15) >>> 4;
    y1 = (ay > by ? ay : by); y1 = (y1 > cy ? y1 : cy); y1 = (y1 + 15) >>> 4;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > W - 1) x1 = W - 1;
    if (y1 > H - 1) y1 = H - 1;
    for (longint y = y0; y < y1; y++) begin
      for (longint x = x0; x < x1; x++) begin
        px = x * 16 + 8;
        py = y * 16 + 8;
        eab = cross2(bx - ax, by - ay, px - ax, py - ay);
        ebc = cross2(cx - bx, cy - by, px - bx, py - by);
        eca = cross2(ax - cx, ay - cy, px - cx, py - cy);
        if (eab >= 0 && ebc >= 0 && eca >= 0) begin
          num = ebc * az + eca * bz + eab * cz;
          // round to nearest, halves up
          q = (2 * num + d) / (2 * d);
          if (((2 * num + d) % (2 * d)) != 0 && (2 * num + d) < 0) q = q - 1;
          z = q;
          if (z > 32767) z = 32767;
          if (z < -32768) z = -32768;
          idx = int'((H - 1 - y) * W + x);
          if (z < shadow_depth[idx]) begin
            shadow_depth[idx] = 16'(z);
            shadow_color[idx] = r.tri_color;
            count++;
          end
        end
      end
    end
    return count;
  endfunction

  // update the shadow frame for one taken request and queue its result
  function automatic void predict_request(req_t r);
    res_t e;
    e = '0;
    e.result_kind = r.req_type;
    case (r.req_type)
      REQ_CLEAR: begin
        for (int i = 0; i < NPIX; i++) begin
          shadow_color[i] = GREY;
          shadow_depth[i] = far_z;
        end
      end
      REQ_DRAW: e.pixels_written = 13'(rasterize_draw(r));
      REQ_READ: begin
        e.pixel_color = shadow_color[r.pixel_index];
        e.pixel_depth = shadow_depth[r.pixel_index];
      end
      default: return;
    endcase
    results_due.push_back(e);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_request(req);
      if (!(start && busy)) begin
        if (pending_reqs.size() > 0 && int'($urandom_range(99)) >= idle_pct) begin
          req <= pending_reqs.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && result_valid) begin
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", result);
      end else begin
        e = results_due.pop_front();
        if (result.result_kind !== e.result_kind || result.pixel_color !== e.pixel_color ||
            result.pixel_depth !== e.pixel_depth ||
            result.pixels_written !== e.pixels_written) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", e, result);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic req_t make_draw(int ax, int ay, int az, int bx, int by, int bz,
                                     int cx, int cy, int cz, logic [23:0] col);
    req_t r;
    r = '0;
    r.req_type = REQ_DRAW;
    r.ax = 16'(ax); r.ay = 16'(ay); r.az = 16'(az);
    r.bx = 16'(bx); r.by_coord = 16'(by); r.bz = 16'(bz);
    r.cx = 16'(cx); r.cy = 16'(cy); r.cz = 16'(cz);
    r.tri_color = col;
    r.pixel_index = 12'($urandom);
    return r;
  endfunction

  function automatic req_t make_simple(logic [1:0] kind, int pix);
    req_t r;
    r = ($bits(req_t))'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.req_type = kind;
    r.pixel_index = 12'(pix);
    return r;
  endfunction

  // random triangle, usually small, with random winding and depths
  function automatic req_t random_triangle();
    int bx0, by0, span;
    int zlo;
    bx0 = int'($urandom_range(1100)) - 40;
    by0 = int'($urandom_range(1100)) - 40;
    span = ($urandom_range(19) == 0) ? 1200 : 240;
    zlo = ($urandom_range(5) == 0) ? -2000 : 0;
    return make_draw(bx0 + int'($urandom_range(span)), by0 + int'($urandom_range(span)),
                     zlo + int'($urandom_range(30000)),
                     bx0 + int'($urandom_range(span)), by0 + int'($urandom_range(span)),
                     zlo + int'($urandom_range(30000)),
                     bx0 + int'($urandom_range(span)), by0 + int'($urandom_range(span)),
                     zlo + int'($urandom_range(30000)), 24'($urandom));
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || start || results_due.size() > 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_FAR_DEPTH) far_z = val;
    else if (idx == CFG_CLIP_EN) clip_on = val[0];
    cfg_valid <= 1'b0;
  endtask

  task automatic random_batch(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = int'($urandom_range(99));
      if (pick < 8) pending_reqs.push_back(make_simple(REQ_CLEAR, 0));
      else if (pick < 62) pending_reqs.push_back(random_triangle());
      else if (pick < 90) pending_reqs.push_back(make_simple(REQ_READ, int'($urandom_range(NPIX - 1))));
      else if (pick < 95) pending_reqs.push_back(make_simple(2'($urandom),
                                                             int'($urandom_range(NPIX - 1))));
      else begin
        pending_reqs.push_back(make_simple(REQ_NONE, 0));
        i--;
      end
    end
  endtask

  // stimulus phases
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    drain();

    // directed: clear, full-frame draws, windings, depth rules, reads
    pending_reqs.push_back(make_simple(REQ_READ, 0));
    pending_reqs.push_back(make_simple(REQ_CLEAR, 0));
    pending_reqs.push_back(make_draw(0, 0, 0, 1024, 0, 100, 0, 1024, 30000, 24'hFF0000));
    pending_reqs.push_back(make_simple(REQ_READ, 63 * 64));
    pending_reqs.push_back(make_simple(REQ_READ, 4095));
    pending_reqs.push_back(make_draw(0, 0, 0, 1024, 0, 100, 0, 1024, 30000, 24'h00FF00));
    pending_reqs.push_back(make_draw(0, 0, 0, 0, 1024, 100, 1024, 0, 30000, 24'h0000FF));
    pending_reqs.push_back(make_draw(0, 0, 5, 512, 512, 5, 1024, 1024, 5, 24'h123456));
    pending_reqs.push_back(make_draw(100, 100, -5, 600, 100, 10, 100, 600, 10, 24'hABCDEF));
    pending_reqs.push_back(make_draw(-32768, -32768, 32767, 32767, -32768, 32767,
                                     -32768, 32767, 32767, 24'hFFFFFF));
    pending_reqs.push_back(make_draw(32767, 32767, 0, -32768, 32767, 0, 32767, -32768, 0,
                                     24'h000000));
    pending_reqs.push_back(make_simple(REQ_NONE, 0));
    pending_reqs.push_back(make_draw(200, 200, 0, 800, 220, 0, 300, 900, 0, 24'h00AA55));
    pending_reqs.push_back(make_simple(REQ_READ, 40 * 64 + 20));
    pending_reqs.push_back(make_simple(REQ_READ, 2048));
    drain();

    idle_pct = 49;
    write_reg(CFG_FAR_DEPTH, 16'h8000);
    write_reg(CFG_CLIP_EN, 16'd0);
    pending_reqs.push_back(make_simple(REQ_CLEAR, 0));
    pending_reqs.push_back(make_draw(100, 100, -5, 600, 100, -32768, 100, 600, 10, 24'h5A5A5A));
    pending_reqs.push_back(make_simple(REQ_READ, 50 * 64 + 10));
    random_batch(30);
    drain();

    idle_pct = 27;
    write_reg(CFG_FAR_DEPTH, 16'd0);
    write_reg(CFG_CLIP_EN, 16'd1);
    random_batch(35);
    drain();

    idle_pct = 0;
    write_reg(CFG_FAR_DEPTH, 16'($urandom));
    write_reg(CFG_CLIP_EN, 16'hFFFE);
    random_batch(35);
    drain();

    idle_pct = 49;
    write_reg(CFG_FAR_DEPTH, 16'h7FFF);
    write_reg(CFG_CLIP_EN, 16'd1);
    random_batch(30);
    drain();

    if (errors == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
